@@ rtl/core/ofvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofvc_pkg
// Shared types and constants for the optical flow velocity compensation block.
// ----------------------------------------------------------------------------
package ofvc_pkg;

	localparam int IN_W      = 112;
	localparam int OUT_W     = 96;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_VALID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 3'd4;

	localparam logic [15:0] RST_MIN_HEIGHT   = 16'd80;
	localparam logic [15:0] RST_MAX_HEIGHT   = 16'd4000;
	localparam logic [19:0] RST_TILT_GAIN    = 20'd130980;
	localparam logic [23:0] RST_HEIGHT_SCALE = 24'd34341;

	localparam int MUL_W     = 24;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = 64;
	localparam int WORK_W    = 48;
	localparam int MAG_W     = 38;
	localparam int DVS_W     = 44;
	localparam int QUO_W     = 31;
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [MUL_W-1:0] US_PER_S = 24'd1000000;
	localparam logic [31:0]      VEL_MAX  = 32'h7fff_ffff;

	typedef enum logic [1:0] {
		MS_HEIGHT = 2'd0,
		MS_SCALE  = 2'd1,
		MS_MEGA   = 2'd2
	} mul_stage_t;

	typedef struct packed {
		logic       load;
		logic       tilt;
		logic       comb;
		logic       mul_lo;
		logic       mul_hi;
		logic       axis;
		mul_stage_t stage;
		logic       div_load;
		logic       div_step;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic compute;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/core/ofvc_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofvc_divider
// Restoring divider, one quotient bit per step, with overflow detect at load.
// ----------------------------------------------------------------------------
module ofvc_divider (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic [ofvc_pkg::ACC_W-1:0]    dividend,
	input  logic [ofvc_pkg::DVS_W-1:0]    divisor,
	output logic [ofvc_pkg::QUO_W-1:0]    quotient,
	output logic                          sat
);

	localparam int DW = ofvc_pkg::DVS_W;
	localparam int QW = ofvc_pkg::QUO_W;
	localparam int HW = ofvc_pkg::ACC_W - QW;

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [QW-1:0] quo_q;
	logic          sat_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          q_bit;

	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		diff  = trial - {1'b0, dvs_q};
		q_bit = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sat_q <= {{(DW-HW){1'b0}}, dividend[ofvc_pkg::ACC_W-1:QW]} >= divisor;
			rem_q <= {{(DW-HW){1'b0}}, dividend[ofvc_pkg::ACC_W-1:QW]};
			quo_q <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (step) begin
			rem_q <= q_bit ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], q_bit};
		end
	end

	assign quotient = quo_q;
	assign sat      = sat_q;

endmodule

@@ rtl/core/ofvc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofvc_datapath
// Config registers, sample state, shared 24x24 multiplier, dividers, output.
// ----------------------------------------------------------------------------
module ofvc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ofvc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ofvc_pkg::CFG_W-1:0]        cfg_data,
	input  logic [ofvc_pkg::IN_W-1:0]         s_tdata,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [ofvc_pkg::OUT_W-1:0]        m_tdata,
	output logic                              m_tuser,
	input  ofvc_pkg::dp_cmd_t                 cmd,
	output ofvc_pkg::dp_stat_t                stat
);

	localparam int MW = ofvc_pkg::MUL_W;
	localparam int PW = ofvc_pkg::PROD_W;
	localparam int AW = ofvc_pkg::ACC_W;
	localparam int WW = ofvc_pkg::WORK_W;
	localparam int CW = ofvc_pkg::MAG_W;
	localparam int QW = ofvc_pkg::QUO_W;

	function automatic logic [15:0] neg_sat(input logic [15:0] v);
		return (v == 16'h8000) ? 16'h7fff : (16'd0 - v);
	endfunction

	// config
	logic        sensor_valid_q;
	logic [15:0] min_height_q;
	logic [15:0] max_height_q;
	logic [19:0] tilt_gain_q;
	logic [23:0] height_scale_q;

	// state kept between samples
	logic [31:0] last_time_q;
	logic [15:0] prev_roll_q;
	logic [15:0] prev_pitch_q;

	// per-sample working registers
	logic        valid_q;
	logic        win_q;
	logic [15:0] fx_q;
	logic [15:0] fy_q;
	logic [15:0] h_q;
	logic [31:0] dt_q;
	logic [15:0] dp_mag_q;
	logic        dp_neg_q;
	logic [15:0] dr_mag_q;
	logic        dr_neg_q;
	logic [AW-1:0] acc_q;
	logic [WW-1:0] w_q;
	logic [AW-1:0] e_q [2];
	logic [1:0]    neg_q;
	logic [1:0]    mz_q;

	logic                       m_tvalid_q;
	logic [ofvc_pkg::OUT_W-1:0] tdata_q;
	logic                       tuser_q;

	// input fields
	logic [15:0] in_dx, in_dy, in_roll, in_pitch, in_h;
	logic [31:0] in_ts;
	logic [16:0] dp17, dr17, dp_abs, dr_abs;
	logic        in_win;

	assign in_dx    = s_tdata[15:0];
	assign in_dy    = s_tdata[31:16];
	assign in_roll  = s_tdata[47:32];
	assign in_pitch = s_tdata[63:48];
	assign in_h     = s_tdata[79:64];
	assign in_ts    = s_tdata[111:80];

	always_comb begin
		dp17   = {in_pitch[15], in_pitch} - {prev_pitch_q[15], prev_pitch_q};
		dr17   = {in_roll[15], in_roll} - {prev_roll_q[15], prev_roll_q};
		dp_abs = dp17[16] ? (17'd0 - dp17) : dp17;
		dr_abs = dr17[16] ? (17'd0 - dr17) : dr17;
		in_win = (in_h > min_height_q) && (in_h < max_height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_valid_q <= 1'b0;
			min_height_q   <= ofvc_pkg::RST_MIN_HEIGHT;
			max_height_q   <= ofvc_pkg::RST_MAX_HEIGHT;
			tilt_gain_q    <= ofvc_pkg::RST_TILT_GAIN;
			height_scale_q <= ofvc_pkg::RST_HEIGHT_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ofvc_pkg::CFG_SENSOR_VALID: sensor_valid_q <= cfg_data[0];
				ofvc_pkg::CFG_MIN_HEIGHT:   min_height_q   <= cfg_data[15:0];
				ofvc_pkg::CFG_MAX_HEIGHT:   max_height_q   <= cfg_data[15:0];
				ofvc_pkg::CFG_TILT_GAIN:    tilt_gain_q    <= cfg_data[19:0];
				ofvc_pkg::CFG_HEIGHT_SCALE: height_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q  <= '0;
			prev_roll_q  <= '0;
			prev_pitch_q <= '0;
			valid_q      <= 1'b0;
			win_q        <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= sensor_valid_q;
			win_q   <= in_win;
			if (sensor_valid_q && in_win) begin
				last_time_q  <= in_ts;
				prev_roll_q  <= in_roll;
				prev_pitch_q <= in_pitch;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fx_q     <= neg_sat(in_dy);
			fy_q     <= neg_sat(in_dx);
			h_q      <= in_h;
			dt_q     <= in_ts - last_time_q;
			dp_mag_q <= dp_abs[15:0];
			dp_neg_q <= dp17[16];
			dr_mag_q <= dr_abs[15:0];
			dr_neg_q <= dr17[16];
		end
	end

	// shared multiplier
	logic [MW-1:0] mult_a, mult_b;
	logic [PW-1:0] prod;
	logic [AW-1:0] acc_sum;

	always_comb begin
		if (cmd.tilt) begin
			mult_a = {8'd0, (cmd.axis ? dr_mag_q : dp_mag_q)};
			mult_b = {4'd0, tilt_gain_q};
		end else begin
			mult_a = cmd.mul_hi ? w_q[WW-1:MW] : w_q[MW-1:0];
			case (cmd.stage)
				ofvc_pkg::MS_HEIGHT: mult_b = {8'd0, h_q};
				ofvc_pkg::MS_SCALE:  mult_b = height_scale_q;
				ofvc_pkg::MS_MEGA:   mult_b = ofvc_pkg::US_PER_S;
				default:             mult_b = '0;
			endcase
		end
		prod    = mult_a * mult_b;
		acc_sum = acc_q + {prod[AW-MW-1:0], {MW{1'b0}}};
	end

	// tilt compensation of the selected axis
	logic [15:0]   f_sel;
	logic          term_neg;
	logic [CW-1:0] base, tilt_term, c_val, c_mag;

	always_comb begin
		f_sel     = cmd.axis ? fy_q : fx_q;
		term_neg  = cmd.axis ? ~dr_neg_q : dp_neg_q;
		base      = {f_sel[15], f_sel, 21'd0};
		tilt_term = {2'd0, acc_q[35:0]};
		c_val     = term_neg ? (base - tilt_term) : (base + tilt_term);
		c_mag     = c_val[CW-1] ? ({CW{1'b0}} - c_val) : c_val;
	end

	always_ff @(posedge clk) begin
		if (cmd.tilt || cmd.mul_lo) begin
			acc_q <= {{(AW-PW){1'b0}}, prod};
		end else if (cmd.mul_hi) begin
			acc_q <= acc_sum;
		end
		if (cmd.comb) begin
			w_q             <= {{(WW-CW){1'b0}}, c_mag};
			neg_q[cmd.axis] <= c_val[CW-1];
			mz_q[cmd.axis]  <= (c_val == '0);
		end else if (cmd.mul_hi) begin
			case (cmd.stage)
				ofvc_pkg::MS_HEIGHT: w_q <= acc_sum[WW+12:13];
				ofvc_pkg::MS_SCALE:  w_q <= {4'd0, acc_sum[AW-1:20]};
				ofvc_pkg::MS_MEGA:   e_q[cmd.axis] <= acc_sum;
				default: ;
			endcase
		end
	end

	// dividers, one per axis
	logic [QW-1:0] quo_x, quo_y;
	logic          sat_x, sat_y;
	logic [ofvc_pkg::DVS_W-1:0] divisor;

	assign divisor = {dt_q, 12'd0};

	ofvc_divider u_div_x (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (e_q[0]),
		.divisor  (divisor),
		.quotient (quo_x),
		.sat      (sat_x)
	);

	ofvc_divider u_div_y (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (e_q[1]),
		.divisor  (divisor),
		.quotient (quo_y),
		.sat      (sat_y)
	);

	// result
	logic [31:0] mag_x, mag_y, vel_x, vel_y;
	logic        compute;

	assign compute = valid_q & win_q;

	always_comb begin
		mag_x = mz_q[0] ? 32'd0 : (sat_x ? ofvc_pkg::VEL_MAX : {1'b0, quo_x});
		mag_y = mz_q[1] ? 32'd0 : (sat_y ? ofvc_pkg::VEL_MAX : {1'b0, quo_y});
		vel_x = compute ? (neg_q[0] ? (32'd0 - mag_x) : mag_x) : 32'd0;
		vel_y = compute ? (neg_q[1] ? (32'd0 - mag_y) : mag_y) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			tdata_q <= {vel_y, vel_x,
				(valid_q ? fy_q : 16'd0), (valid_q ? fx_q : 16'd0)};
			tuser_q <= compute;
		end
	end

	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = tdata_q;
	assign m_tuser       = tuser_q;
	assign stat.compute  = compute;
	assign stat.out_free = ~m_tvalid_q | m_tready;

endmodule

@@ rtl/core/ofvc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofvc_ctrl
// Sequencer: load, per-axis tilt and multiply chain, divide, output.
// ----------------------------------------------------------------------------
module ofvc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  ofvc_pkg::dp_stat_t  stat,
	output ofvc_pkg::dp_cmd_t   cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_TILT = 8'b0000_0010,
		ST_COMB = 8'b0000_0100,
		ST_MLO  = 8'b0000_1000,
		ST_MHI  = 8'b0001_0000,
		ST_DLD  = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	localparam int CNW = ofvc_pkg::DIV_CNT_W;

	state_t                 state_q;
	logic                   axis_q;
	ofvc_pkg::mul_stage_t   stage_q;
	logic [CNW-1:0]         cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			stage_q <= ofvc_pkg::MS_HEIGHT;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_TILT;
						axis_q  <= 1'b0;
					end
				end
				ST_TILT: begin
					state_q <= stat.compute ? ST_COMB : ST_FIN;
				end
				ST_COMB: begin
					state_q <= ST_MLO;
					stage_q <= ofvc_pkg::MS_HEIGHT;
				end
				ST_MLO: begin
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					case (stage_q)
						ofvc_pkg::MS_HEIGHT: begin
							stage_q <= ofvc_pkg::MS_SCALE;
							state_q <= ST_MLO;
						end
						ofvc_pkg::MS_SCALE: begin
							stage_q <= ofvc_pkg::MS_MEGA;
							state_q <= ST_MLO;
						end
						default: begin
							stage_q <= ofvc_pkg::MS_HEIGHT;
							if (!axis_q) begin
								axis_q  <= 1'b1;
								state_q <= ST_TILT;
							end else begin
								state_q <= ST_DLD;
							end
						end
					endcase
				end
				ST_DLD: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNW'(ofvc_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load     = (state_q == ST_IDLE) & s_tvalid;
		cmd.tilt     = (state_q == ST_TILT) & stat.compute;
		cmd.comb     = (state_q == ST_COMB);
		cmd.mul_lo   = (state_q == ST_MLO);
		cmd.mul_hi   = (state_q == ST_MHI);
		cmd.axis     = axis_q;
		cmd.stage    = stage_q;
		cmd.div_load = (state_q == ST_DLD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN) & stat.out_free;
	end

endmodule

@@ rtl/core/optical_flow_velocity_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_flow_velocity_compensation
// Tilt-compensated optical flow velocity, fixed point, one result per sample.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                      Contents
// s_*      in   s_tvalid s_tready s_tdata    flow sample
// m_*      out  m_tvalid m_tready m_tdata    flows and velocities
//                         m_tuser            in_range
// cfg_*    in   cfg_we cfg_index cfg_data    register write, no read-back
//
// An in-window transaction runs the 31-step bit-serial divide plus two
// multiply chains, one per axis, on the shared 24x24 multiplier.
// Out of window or sensor invalid, the multiply chains and divide are skipped.
// One transaction at a time; the output register frees input while a result
// waits, and the final step stalls only while that register is full.
// Reset clears config to defaults, sample state to zero, and empties output.
// ----------------------------------------------------------------------------
module optical_flow_velocity_compensation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sensor_dx, sensor_dy, roll_angle, pitch_angle, height_mm, timestamp_us
	input  logic [ofvc_pkg::IN_W-1:0]         s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// flow_x, flow_y, velocity_x, velocity_y
	output logic [ofvc_pkg::OUT_W-1:0]        m_tdata,
	// in_range
	output logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic [ofvc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ofvc_pkg::CFG_W-1:0]        cfg_data
);

	ofvc_pkg::dp_cmd_t  cmd;
	ofvc_pkg::dp_stat_t stat;

	ofvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ofvc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ rtl/core/ofvc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofvc_checker
// Port-level checks for the optical flow velocity compensation block.
// ----------------------------------------------------------------------------
module ofvc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [ofvc_pkg::OUT_W-1:0] m_tdata,
	input logic                       m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while busy");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[95:32] == 64'd0)
		else $error("velocity nonzero when out of range");

	a_vel_sym: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:32] != 32'h8000_0000) && (m_tdata[95:64] != 32'h8000_0000))
		else $error("velocity outside saturation limit");

	a_flow_sym: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
		else $error("flow outside saturation limit");

endmodule

bind optical_flow_velocity_compensation ofvc_checker u_ofvc_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for optical_flow_velocity_compensation.
// Streams flow samples through the slave port, predicts each result with an
// independent fixed-point model of the tilt compensation and the velocity
// scaling, and checks every master transaction field by field. Covers
// sensor-invalid, out-of-window, zero elapsed time, timestamp wrap,
// saturation and register extremes, with random gaps and stalls on both
// sides and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [63:0] SPEED_LIMIT = 64'h7fff_ffff;

	typedef struct packed {
		logic [31:0]        ts;
		logic [15:0]        height;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic signed [15:0] dy;
		logic signed [15:0] dx;
	} flow_sample_t;

	typedef struct packed {
		logic signed [31:0] vy;
		logic signed [31:0] vx;
		logic signed [15:0] fy;
		logic signed [15:0] fx;
	} flow_velocity_t;

	typedef struct packed {
		logic           in_range;
		flow_velocity_t word;
	} velocity_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// sensor_dx, sensor_dy, roll_angle, pitch_angle, height_mm, timestamp_us
	logic [ofvc_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// flow_x, flow_y, velocity_x, velocity_y
	logic [ofvc_pkg::OUT_W-1:0] m_tdata;
	// in_range
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [ofvc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ofvc_pkg::CFG_W-1:0] cfg_data = '0;

	optical_flow_velocity_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// register shadow
	logic        cf_valid = 1'b0;
	logic [15:0] cf_min = 16'd80;
	logic [15:0] cf_max = 16'd4000;
	logic [19:0] cf_gain = 20'd130980;
	logic [23:0] cf_scale = 24'd34341;

	// last in-window sample
	logic [31:0]        pv_ts = '0;
	logic signed [15:0] pv_roll = '0;
	logic signed [15:0] pv_pitch = '0;

	flow_sample_t     sample_q[$];
	velocity_result_t velocity_q[$];

	int s_issued = 0;
	int s_accepted = 0;
	int s_gap = 0;
	bit s_calm = 1'b0;
	int m_got = 0;
	int r_seen = 0;
	int r_stall = 0;
	int r_hold = 0;
	bit r_calm = 1'b0;
	int err_count = 0;

	logic [31:0]        gen_ts = '0;
	logic signed [15:0] gen_roll = '0;
	logic signed [15:0] gen_pitch = '0;

	function automatic logic [31:0] scaled_speed(input longint comp, input logic [15:0] h,
			input logic [31:0] dt);
		logic [63:0] m, a, b, d, e, mag;
		logic neg;
		neg = comp < 0;
		m = neg ? 64'(-comp) : 64'(comp);
		if (m == 0) begin
			mag = '0;
		end else if (dt == 0) begin
			mag = SPEED_LIMIT;
		end else begin
			a = m * {48'd0, h};
			b = a >> 13;
			d = b * {40'd0, cf_scale};
			d = d >> 20;
			e = d * 64'd1000000;
			mag = e / ({32'd0, dt} << 12);
			if (mag > SPEED_LIMIT)
				mag = SPEED_LIMIT;
		end
		return neg ? -mag[31:0] : mag[31:0];
	endfunction

	function automatic velocity_result_t compensate_sample(input flow_sample_t s);
		velocity_result_t r;
		longint fx, fy, cx, cy;
		logic [31:0] dt;
		r = '0;
		if (!cf_valid)
			return r;
		fx = -longint'(s.dy);
		fy = -longint'(s.dx);
		if (fx > 32767)
			fx = 32767;
		if (fy > 32767)
			fy = 32767;
		r.word.fx = fx[15:0];
		r.word.fy = fy[15:0];
		if (s.height > cf_min && s.height < cf_max) begin
			dt = s.ts - pv_ts;
			cx = fx * 2097152 + (longint'(s.pitch) - longint'(pv_pitch)) * longint'(cf_gain);
			cy = fy * 2097152 - (longint'(s.roll) - longint'(pv_roll)) * longint'(cf_gain);
			pv_ts = s.ts;
			pv_roll = s.roll;
			pv_pitch = s.pitch;
			r.word.vx = scaled_speed(cx, s.height, dt);
			r.word.vy = scaled_speed(cy, s.height, dt);
			r.in_range = 1'b1;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input longint got, input longint want);
		err_count++;
		if (err_count <= 40)
			$display("MISMATCH result %0d %s: got %0d expected %0d", m_got, field, got, want);
	endtask

	// monitor: check outputs before recording new input so a same-edge pair stays ordered
	always @(posedge clk) begin
		velocity_result_t want;
		flow_velocity_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				m_got++;
				got = m_tdata;
				if (velocity_q.size() == 0) begin
					flag_mismatch("unexpected transaction", 0, 0);
				end else begin
					want = velocity_q.pop_front();
					if (got.fx !== want.word.fx)
						flag_mismatch("flow_x", got.fx, want.word.fx);
					if (got.fy !== want.word.fy)
						flag_mismatch("flow_y", got.fy, want.word.fy);
					if (got.vx !== want.word.vx)
						flag_mismatch("velocity_x", got.vx, want.word.vx);
					if (got.vy !== want.word.vy)
						flag_mismatch("velocity_y", got.vy, want.word.vy);
					if (m_tuser !== want.in_range)
						flag_mismatch("in_range", m_tuser, want.in_range);
				end
			end
			if (s_tvalid && s_tready) begin
				velocity_q.push_back(compensate_sample(s_tdata));
				s_accepted++;
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_accepted == s_issued) begin
			if (s_gap > 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				s_tdata <= sample_q.pop_front();
				s_tvalid <= 1'b1;
				s_issued++;
				if (s_issued % 25 == 0)
					s_calm = ($urandom_range(0, 3) == 0);
				s_gap = s_calm ? 0 : $urandom_range(0, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off mid-run
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_got != r_seen) begin
				r_seen = m_got;
				if (r_seen % 25 == 0)
					r_calm = ($urandom_range(0, 3) == 0);
				r_stall = r_calm ? 0 : $urandom_range(0, 18);
				if (r_seen == 150)
					r_hold = 700;
			end
			if (r_hold > 0) begin
				r_hold--;
				m_tready <= 1'b0;
			end else if (r_stall > 0) begin
				r_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [ofvc_pkg::CFG_IDX_W-1:0] idx,
			input logic [ofvc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ofvc_pkg::CFG_SENSOR_VALID: cf_valid = val[0];
			ofvc_pkg::CFG_MIN_HEIGHT:   cf_min = val[15:0];
			ofvc_pkg::CFG_MAX_HEIGHT:   cf_max = val[15:0];
			ofvc_pkg::CFG_TILT_GAIN:    cf_gain = val[19:0];
			ofvc_pkg::CFG_HEIGHT_SCALE: cf_scale = val[23:0];
			default: ;
		endcase
	endtask

	task automatic queue_sample(input int dx, input int dy, input int roll, input int pitch,
			input int height, input logic [31:0] ts);
		flow_sample_t s;
		s.dx = dx[15:0];
		s.dy = dy[15:0];
		s.roll = roll[15:0];
		s.pitch = pitch[15:0];
		s.height = height[15:0];
		s.ts = ts;
		sample_q.push_back(s);
	endtask

	task automatic queue_random(input int count);
		flow_sample_t s;
		int kind;
		int v;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				s.dx = 16'($urandom);
				s.dy = 16'($urandom);
			end else begin
				v = int'($urandom_range(0, 400)) - 200;
				s.dx = v[15:0];
				v = int'($urandom_range(0, 400)) - 200;
				s.dy = v[15:0];
			end
			if (kind == 4) begin
				gen_roll = 16'($urandom);
				gen_pitch = 16'($urandom);
			end else begin
				gen_roll = gen_roll + 16'($urandom_range(0, 600)) - 16'd300;
				gen_pitch = gen_pitch + 16'($urandom_range(0, 600)) - 16'd300;
			end
			s.roll = gen_roll;
			s.pitch = gen_pitch;
			if (kind < 8 && cf_max > cf_min + 1)
				s.height = 16'($urandom_range(cf_min + 1, cf_max - 1));
			else
				s.height = 16'($urandom);
			if (kind == 9)
				gen_ts = $urandom;
			else if (kind != 0)
				gen_ts = gen_ts + $urandom_range(1, 40000);
			s.ts = gen_ts;
			sample_q.push_back(s);
		end
	endtask

	task automatic wait_drained();
		while (sample_q.size() != 0 || s_accepted != s_issued || velocity_q.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// sensor not yet valid: everything zero, state untouched
		queue_sample(-32768, 32767, 1000, -1000, 1000, 32'd500);
		queue_sample(123, -456, 0, 0, 50, 32'd600);
		queue_sample(0, 0, 0, 0, 2000, 32'd700);
		wait_drained();

		write_reg(ofvc_pkg::CFG_SENSOR_VALID, 24'd1);
		queue_sample(0, 0, 0, 0, 1000, 32'd1000);
		queue_sample(-32768, -32768, 100, -100, 1000, 32'd2000);
		queue_sample(32767, 32767, 32767, -32768, 1000, 32'd3000);
		queue_sample(5, -7, -32768, 32767, 81, 32'd4000);
		queue_sample(5, -7, 0, 0, 80, 32'd5000);
		queue_sample(5, -7, 0, 0, 3999, 32'd6000);
		queue_sample(5, -7, 0, 0, 4000, 32'd7000);
		queue_sample(1, 1, 0, 0, 0, 32'd8000);
		queue_sample(1, 1, 0, 0, 65535, 32'd9000);
		// zero elapsed time, nonzero then zero compensated flow
		queue_sample(10, -10, 0, 0, 1000, 32'd6000);
		queue_sample(0, 0, 0, 0, 1000, 32'd6000);
		// timestamp going backwards wraps
		queue_sample(0, 0, 0, 0, 1000, 32'd100);
		queue_sample(-32768, 32767, 0, 0, 3999, 32'd101);
		queue_sample(100, -100, 800, -800, 500, 32'd20101);
		queue_sample(-3, 4, 820, -790, 1500, 32'd25000);
		queue_sample(0, 0, -32768, 32767, 2000, 32'hffff_ffff);
		queue_sample(0, 0, 32767, -32768, 2000, 32'd0);
		queue_sample(-1, 32767, -8192, 8191, 3000, 32'd1);
		wait_drained();

		write_reg(ofvc_pkg::CFG_MIN_HEIGHT, 24'd0);
		write_reg(ofvc_pkg::CFG_MAX_HEIGHT, 24'd65535);
		write_reg(ofvc_pkg::CFG_TILT_GAIN, 24'($urandom_range(0, 300000)));
		write_reg(ofvc_pkg::CFG_HEIGHT_SCALE, 24'($urandom_range(0, 200000)));
		queue_random(300);
		wait_drained();

		write_reg(ofvc_pkg::CFG_TILT_GAIN, 24'hf_ffff);
		write_reg(ofvc_pkg::CFG_HEIGHT_SCALE, 24'hff_ffff);
		queue_random(60);
		wait_drained();

		// empty window
		write_reg(ofvc_pkg::CFG_MIN_HEIGHT, 24'd65535);
		write_reg(ofvc_pkg::CFG_MAX_HEIGHT, 24'd0);
		write_reg(ofvc_pkg::CFG_TILT_GAIN, 24'd0);
		write_reg(ofvc_pkg::CFG_HEIGHT_SCALE, 24'd0);
		queue_random(30);
		wait_drained();

		write_reg(ofvc_pkg::CFG_SENSOR_VALID, 24'd0);
		write_reg(ofvc_pkg::CFG_MIN_HEIGHT, 24'd100);
		write_reg(ofvc_pkg::CFG_MAX_HEIGHT, 24'd5000);
		queue_random(20);
		wait_drained();

		// writes past the last register are ignored
		for (int k = int'(ofvc_pkg::CFG_HEIGHT_SCALE) + 1; k < (1 << ofvc_pkg::CFG_IDX_W); k++)
			write_reg(ofvc_pkg::CFG_IDX_W'(k), 24'($urandom));
		write_reg(ofvc_pkg::CFG_SENSOR_VALID, 24'd1);
		write_reg(ofvc_pkg::CFG_MIN_HEIGHT, 24'($urandom_range(0, 2000)));
		write_reg(ofvc_pkg::CFG_MAX_HEIGHT, 24'($urandom_range(3000, 65535)));
		write_reg(ofvc_pkg::CFG_TILT_GAIN, 24'($urandom_range(0, 1048575)));
		write_reg(ofvc_pkg::CFG_HEIGHT_SCALE, 24'($urandom_range(0, 16777215)));
		queue_random(60);
		wait_drained();

		repeat (100) @(negedge clk);
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ optical_flow_velocity_compensation.f @@
rtl/core/ofvc_pkg.sv
rtl/core/ofvc_divider.sv
rtl/core/ofvc_datapath.sv
rtl/core/ofvc_ctrl.sv
rtl/core/optical_flow_velocity_compensation.sv
rtl/core/ofvc_checker.sv
tb/sv/tb.sv
